@@ rtl/core/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, widths and constants for the feathered rounded-rect coverage
// pipeline.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // configuration port
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_HOLE_LEFT     = 3'd0,
    REG_HOLE_TOP      = 3'd1,
    REG_HOLE_WIDTH    = 3'd2,
    REG_HOLE_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_EDGE_SIGMA    = 3'd5
  } reg_idx_t;

  // sigma below this code is a hard edge
  localparam logic [CFG_W-1:0] HARD_SIGMA_LIMIT = 16'd3;

  // geometry, 1/32 pixel units
  localparam int GQ_W  = 20;
  localparam int OX_W  = 18;
  localparam int SQR_W = 2 * OX_W;

  // square root unit
  localparam int RAD_W     = 54;
  localparam int ROOT_W    = 27;
  localparam int SQ_REM_W  = 31;
  localparam int SQ_STAGES = RAD_W / 2;

  // signed distance, 1/8192 pixel units
  localparam int DF_W  = 29;
  localparam int ABS_W = 27;

  // z = |d| / (sigma * sqrt2), Q16, limited to 8.0
  localparam logic [16:0] SQRT2_Q16 = 17'd92682;
  localparam int ZNUM_W   = 38;
  localparam int Z_W      = 20;
  localparam int ZQ_STEPS = 20;
  localparam int ZHI_W    = ZNUM_W - ZQ_STEPS;
  localparam logic [Z_W-1:0] Z_LIMIT = 20'd524288;

  // t = 1 / (1 + p*z), Q16
  localparam logic [14:0] ERF_P_Q16 = 15'd21469;
  localparam int DEN_W   = 18;
  localparam int T_W     = 17;
  localparam int T_STEPS = 17;

  // polynomial, Q16
  localparam int P_W = 20;
  localparam logic signed [P_W-1:0] ERF_A1 = 20'sd16701;
  localparam logic signed [P_W-1:0] ERF_A2 = -20'sd18645;
  localparam logic signed [P_W-1:0] ERF_A3 = 20'sd93154;
  localparam logic signed [P_W-1:0] ERF_A4 = -20'sd95234;
  localparam logic signed [P_W-1:0] ERF_A5 = 20'sd69560;

  // exp(-u) through 2^-v
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] POW2_FRAC [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768};

  // stage counts
  localparam int GEO_LAT   = 3;
  localparam int SQ_LAT    = SQ_STAGES;
  localparam int DF_LAT    = 1;
  localparam int ZDIV_LAT  = ZQ_STEPS + 3;
  localparam int RCP_LAT   = T_STEPS + 1;
  localparam int ERF_LAT   = 7;
  localparam int TOTAL_LAT = GEO_LAT + SQ_LAT + DF_LAT + ZDIV_LAT + RCP_LAT + ERF_LAT;

  // sideband that rides with the root
  typedef struct packed {
    logic                   valid;
    logic signed [DF_W-1:0] lin;
  } sq_side_t;

  // sideband after the distance is known
  typedef struct packed {
    logic valid;
    logic neg;
  } pl_side_t;

  // Q16 product, rounded to nearest, ties away from zero
  function automatic logic signed [P_W-1:0] qmul(input logic signed [P_W-1:0] a,
                                                 input logic [T_W-1:0] b);
    logic signed [P_W+T_W:0] p;
    logic [P_W+T_W:0] mag;
    logic [P_W+T_W:0] rnd;
    p   = a * $signed({1'b0, b});
    mag = p[P_W+T_W] ? $unsigned(-p) : $unsigned(p);
    rnd = (mag + (P_W+T_W+1)'(32768)) >> 16;
    return p[P_W+T_W] ? -$signed(rnd[P_W-1:0]) : $signed(rnd[P_W-1:0]);
  endfunction

endpackage

@@ rtl/core/fsc_sqrt.sv @@
// ----------------------------------------------------------------------------
// fsc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fsc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  fsc_pkg::sq_side_t          in_side,
  input  logic [fsc_pkg::RAD_W-1:0]  rad,
  output fsc_pkg::sq_side_t          out_side,
  output logic [fsc_pkg::ROOT_W-1:0] root
);
  import fsc_pkg::*;

  logic                  vld_s  [SQ_STAGES];
  logic signed [DF_W-1:0] lin_s [SQ_STAGES];
  logic [RAD_W-1:0]      rad_s  [SQ_STAGES];
  logic [SQ_REM_W-1:0]   rem_s  [SQ_STAGES];
  logic [ROOT_W-1:0]     root_s [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic                   cur_vld;
    logic signed [DF_W-1:0] cur_lin;
    logic [RAD_W-1:0]       cur_rad;
    logic [SQ_REM_W-1:0]    cur_rem;
    logic [ROOT_W-1:0]      cur_root;
    logic [SQ_REM_W-1:0]    r2;
    logic [SQ_REM_W-1:0]    trial;
    logic                   ge;

    if (g == 0) begin : g_first
      assign cur_vld  = in_side.valid;
      assign cur_lin  = in_side.lin;
      assign cur_rad  = rad;
      assign cur_rem  = '0;
      assign cur_root = '0;
    end else begin : g_next
      assign cur_vld  = vld_s[g-1];
      assign cur_lin  = lin_s[g-1];
      assign cur_rad  = rad_s[g-1];
      assign cur_rem  = rem_s[g-1];
      assign cur_root = root_s[g-1];
    end

    // bring down two radicand bits, try root*4+1
    assign r2    = {cur_rem[SQ_REM_W-3:0], cur_rad[RAD_W-1:RAD_W-2]};
    assign trial = SQ_REM_W'({cur_root, 2'b01});
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g] <= 1'b0;
      end else begin
        vld_s[g] <= cur_vld;
      end
      lin_s[g]  <= cur_lin;
      rad_s[g]  <= {cur_rad[RAD_W-3:0], 2'b00};
      rem_s[g]  <= ge ? (r2 - trial) : r2;
      root_s[g] <= {cur_root[ROOT_W-2:0], ge};
    end
  end

  assign out_side.valid = vld_s[SQ_STAGES-1];
  assign out_side.lin   = lin_s[SQ_STAGES-1];
  assign root           = root_s[SQ_STAGES-1];

endmodule

@@ rtl/core/fsc_zdiv.sv @@
// ----------------------------------------------------------------------------
// fsc_zdiv
// Scales |d| by sqrt2 and divides by sigma with a restoring divider, one
// quotient bit per stage; the quotient is limited to 8.0 in Q16.
// ----------------------------------------------------------------------------
module fsc_zdiv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fsc_pkg::CFG_W-1:0] edge_sigma,
  input  fsc_pkg::pl_side_t         in_side,
  input  logic [fsc_pkg::ABS_W-1:0] abs_df,
  output fsc_pkg::pl_side_t         out_side,
  output logic [fsc_pkg::Z_W-1:0]   z
);
  import fsc_pkg::*;

  localparam int PROD_W = ABS_W + 17;

  // scale stage
  logic              m_vld;
  logic              m_neg;
  logic [ZNUM_W-1:0] m_num;
  logic [PROD_W-1:0] prod;

  assign prod = abs_df * SQRT2_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= in_side.valid;
    end
    m_neg <= in_side.neg;
    m_num <= prod[PROD_W-1:6];
  end

  // overflow check: quotient would need more than Z_W bits
  logic              o_vld;
  logic              o_neg;
  logic              o_ovf;
  logic [CFG_W-1:0]  o_rem;
  logic [Z_W-1:0]    o_low;
  logic [ZHI_W-1:0]  hi;

  assign hi = m_num[ZNUM_W-1:ZQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else begin
      o_vld <= m_vld;
    end
    o_neg <= m_neg;
    o_ovf <= hi >= ZHI_W'(edge_sigma);
    o_rem <= hi[CFG_W-1:0];
    o_low <= m_num[ZQ_STEPS-1:0];
  end

  // restoring steps
  logic             vld_s [ZQ_STEPS];
  logic             neg_s [ZQ_STEPS];
  logic             ovf_s [ZQ_STEPS];
  logic [CFG_W-1:0] rem_s [ZQ_STEPS];
  logic [Z_W-1:0]   low_s [ZQ_STEPS];
  logic [Z_W-1:0]   q_s   [ZQ_STEPS];

  for (genvar g = 0; g < ZQ_STEPS; g++) begin : g_step
    logic             cur_vld;
    logic             cur_neg;
    logic             cur_ovf;
    logic [CFG_W-1:0] cur_rem;
    logic [Z_W-1:0]   cur_low;
    logic [Z_W-1:0]   cur_q;
    logic [CFG_W:0]   tt;
    logic [CFG_W:0]   nrem;
    logic             ge;

    if (g == 0) begin : g_first
      assign cur_vld = o_vld;
      assign cur_neg = o_neg;
      assign cur_ovf = o_ovf;
      assign cur_rem = o_rem;
      assign cur_low = o_low;
      assign cur_q   = '0;
    end else begin : g_next
      assign cur_vld = vld_s[g-1];
      assign cur_neg = neg_s[g-1];
      assign cur_ovf = ovf_s[g-1];
      assign cur_rem = rem_s[g-1];
      assign cur_low = low_s[g-1];
      assign cur_q   = q_s[g-1];
    end

    assign tt   = {cur_rem, cur_low[Z_W-1]};
    assign ge   = tt >= {1'b0, edge_sigma};
    assign nrem = ge ? (tt - {1'b0, edge_sigma}) : tt;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g] <= 1'b0;
      end else begin
        vld_s[g] <= cur_vld;
      end
      neg_s[g] <= cur_neg;
      ovf_s[g] <= cur_ovf;
      rem_s[g] <= nrem[CFG_W-1:0];
      low_s[g] <= {cur_low[Z_W-2:0], 1'b0};
      q_s[g]   <= {cur_q[Z_W-2:0], ge};
    end
  end

  // limit to 8.0
  always_ff @(posedge clk) begin
    if (rst) begin
      out_side.valid <= 1'b0;
    end else begin
      out_side.valid <= vld_s[ZQ_STEPS-1];
    end
    out_side.neg <= neg_s[ZQ_STEPS-1];
    z <= (ovf_s[ZQ_STEPS-1] || (q_s[ZQ_STEPS-1] > Z_LIMIT)) ? Z_LIMIT : q_s[ZQ_STEPS-1];
  end

endmodule

@@ rtl/core/fsc_recip.sv @@
// ----------------------------------------------------------------------------
// fsc_recip
// Forms t = round(1 / (1 + p*z)) in Q16 with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module fsc_recip (
  input  logic                    clk,
  input  logic                    rst,
  input  fsc_pkg::pl_side_t       in_side,
  input  logic [fsc_pkg::Z_W-1:0] z,
  output fsc_pkg::pl_side_t       out_side,
  output logic [fsc_pkg::Z_W-1:0] out_z,
  output logic [fsc_pkg::T_W-1:0] t
);
  import fsc_pkg::*;

  localparam int PZ_W  = Z_W + 15;
  localparam int NUM_W = 33;

  // denominator stage
  logic              d_vld;
  logic              d_neg;
  logic [Z_W-1:0]    d_z;
  logic [DEN_W-1:0]  d_den;
  logic [DEN_W-1:0]  d_rem;
  logic [T_W-1:0]    d_low;
  logic [PZ_W-1:0]   pz;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  num;

  assign pz  = z * ERF_P_Q16;
  assign den = DEN_W'(65536) + pz[DEN_W+15:16];
  assign num = {1'b1, 32'd0} + NUM_W'(den >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= in_side.valid;
    end
    d_neg <= in_side.neg;
    d_z   <= z;
    d_den <= den;
    d_rem <= DEN_W'(num[NUM_W-1:T_STEPS]);
    d_low <= num[T_STEPS-1:0];
  end

  // restoring steps
  logic             vld_s [T_STEPS];
  logic             neg_s [T_STEPS];
  logic [Z_W-1:0]   z_s   [T_STEPS];
  logic [DEN_W-1:0] den_s [T_STEPS];
  logic [DEN_W-1:0] rem_s [T_STEPS];
  logic [T_W-1:0]   low_s [T_STEPS];
  logic [T_W-1:0]   q_s   [T_STEPS];

  for (genvar g = 0; g < T_STEPS; g++) begin : g_step
    logic             cur_vld;
    logic             cur_neg;
    logic [Z_W-1:0]   cur_z;
    logic [DEN_W-1:0] cur_den;
    logic [DEN_W-1:0] cur_rem;
    logic [T_W-1:0]   cur_low;
    logic [T_W-1:0]   cur_q;
    logic [DEN_W:0]   tt;
    logic [DEN_W:0]   nrem;
    logic             ge;

    if (g == 0) begin : g_first
      assign cur_vld = d_vld;
      assign cur_neg = d_neg;
      assign cur_z   = d_z;
      assign cur_den = d_den;
      assign cur_rem = d_rem;
      assign cur_low = d_low;
      assign cur_q   = '0;
    end else begin : g_next
      assign cur_vld = vld_s[g-1];
      assign cur_neg = neg_s[g-1];
      assign cur_z   = z_s[g-1];
      assign cur_den = den_s[g-1];
      assign cur_rem = rem_s[g-1];
      assign cur_low = low_s[g-1];
      assign cur_q   = q_s[g-1];
    end

    assign tt   = {cur_rem, cur_low[T_W-1]};
    assign ge   = tt >= {1'b0, cur_den};
    assign nrem = ge ? (tt - {1'b0, cur_den}) : tt;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g] <= 1'b0;
      end else begin
        vld_s[g] <= cur_vld;
      end
      neg_s[g] <= cur_neg;
      z_s[g]   <= cur_z;
      den_s[g] <= cur_den;
      rem_s[g] <= nrem[DEN_W-1:0];
      low_s[g] <= {cur_low[T_W-2:0], 1'b0};
      q_s[g]   <= {cur_q[T_W-2:0], ge};
    end
  end

  assign out_side.valid = vld_s[T_STEPS-1];
  assign out_side.neg   = neg_s[T_STEPS-1];
  assign out_z          = z_s[T_STEPS-1];
  assign t              = q_s[T_STEPS-1];

endmodule

@@ rtl/core/fsc_erf.sv @@
// ----------------------------------------------------------------------------
// fsc_erf
// Horner polynomial in t alongside exp(-z^2), then erf and the coverage
// value with the hard-edge override.
// ----------------------------------------------------------------------------
module fsc_erf (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    hard,
  input  fsc_pkg::pl_side_t       in_side,
  input  logic [fsc_pkg::Z_W-1:0] z,
  input  logic [fsc_pkg::T_W-1:0] t,
  output logic                    done,
  output logic [15:0]             coverage
);
  import fsc_pkg::*;

  // stage valid and sign bits
  logic [5:0] vld;
  logic       neg_a, neg_b, neg_c, neg_d, neg_e, neg_f;
  logic [T_W-1:0] t_a, t_b, t_c, t_d;

  // polynomial
  logic signed [P_W-1:0] p1, p2, p3, p4, p5;

  // exp path
  logic [2*Z_W-1:0] zz;
  logic [23:0]      u;
  logic [40:0]      uv;
  logic [8:0]       n_b, n_c;
  logic [15:0]      f_b;
  logic [16:0]      e_c;
  logic [16:0]      ex_d, ex_e;

  // table interpolation
  logic [16:0] t0, t1;
  logic [28:0] dp;

  // final
  logic signed [P_W-1:0] pe;
  logic signed [P_W:0]   y;
  logic [16:0]           erf_f;
  logic [17:0]           up;
  logic [16:0]           dn;

  assign zz = z * z;
  assign uv = u * LOG2E_Q16;
  assign t0 = POW2_FRAC[{1'b0, f_b[15:12]}];
  assign t1 = POW2_FRAC[{1'b0, f_b[15:12]} + 5'd1];
  assign dp = (t0 - t1) * f_b[11:0];
  assign pe = qmul(p5, ex_e);
  assign y  = (P_W+1)'(65536) - (P_W+1)'(pe);
  assign up = 18'd65536 + {1'b0, erf_f};
  assign dn = 17'd65536 - erf_f;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:0], in_side.valid};
      done <= vld[5];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // stage A: first Horner step, z^2
    p1    <= qmul(ERF_A5, t) + ERF_A4;
    u     <= zz[2*Z_W-1:16];
    t_a   <= t;
    neg_a <= in_side.neg;
    // stage B: second step, times log2(e)
    p2    <= qmul(p1, t_a) + ERF_A3;
    n_b   <= uv[40:32];
    f_b   <= uv[31:16];
    t_b   <= t_a;
    neg_b <= neg_a;
    // stage C: third step, table lookup
    p3    <= qmul(p2, t_b) + ERF_A2;
    e_c   <= t0 - dp[28:12];
    n_c   <= n_b;
    t_c   <= t_b;
    neg_c <= neg_b;
    // stage D: fourth step, integer power
    p4    <= qmul(p3, t_c) + ERF_A1;
    ex_d  <= (n_c >= 9'd17) ? 17'd0 : (e_c >> n_c[4:0]);
    t_d   <= t_c;
    neg_d <= neg_c;
    // stage E: last product with t
    p5    <= qmul(p4, t_d);
    ex_e  <= ex_d;
    neg_e <= neg_d;
    // stage F: erf with limits
    if (y < 0) begin
      erf_f <= 17'd0;
    end else if (y > (P_W+1)'(65536)) begin
      erf_f <= 17'd65536;
    end else begin
      erf_f <= y[16:0];
    end
    neg_f <= neg_e;
    // stage G: coverage
    if (hard) begin
      coverage <= neg_f ? 16'hFFFF : 16'h0000;
    end else if (neg_f) begin
      coverage <= up[17] ? 16'hFFFF : up[16:1];
    end else begin
      coverage <= dn[16:1];
    end
  end

endmodule

@@ rtl/core/feathered_rounded_rect_coverage.sv @@
// ----------------------------------------------------------------------------
// feathered_rounded_rect_coverage
// Coverage of a rounded rectangle with a Gaussian-feathered edge, one sample
// point per clock.
//
//   channel   ports                          direction  handshake
//   request   start, busy, pos_x, pos_y      in         start && !busy
//   result    done, coverage                 out        done, one cycle
//   config    wr_en, wr_index, wr_data       in         wr_en
//
// A request enters every clock; busy stays low. Each sample passes through
// the geometry stages, the 27-stage square root, the 20-step sigma divider,
// the 17-step reciprocal and the erf stages. Reset clears the registers to
// zero and empties the pipeline. The receiver cannot stall, so results move
// on a fixed schedule.
// ----------------------------------------------------------------------------
module feathered_rounded_rect_coverage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [15:0]               pos_x,
  input  logic [15:0]               pos_y,
  input  logic                      wr_en,
  input  logic [fsc_pkg::IDX_W-1:0] wr_index,
  input  logic [fsc_pkg::CFG_W-1:0] wr_data,
  output logic                      done,
  output logic [15:0]               coverage
);
  import fsc_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] hole_left, hole_top, hole_width, hole_height;
  logic [CFG_W-1:0] corner_radius, edge_sigma;

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_left     <= '0;
      hole_top      <= '0;
      hole_width    <= '0;
      hole_height   <= '0;
      corner_radius <= '0;
      edge_sigma    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_HOLE_LEFT:     hole_left     <= wr_data;
        REG_HOLE_TOP:      hole_top      <= wr_data;
        REG_HOLE_WIDTH:    hole_width    <= wr_data;
        REG_HOLE_HEIGHT:   hole_height   <= wr_data;
        REG_CORNER_RADIUS: corner_radius <= wr_data;
        REG_EDGE_SIGMA:    edge_sigma    <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // clamped radius, 1/32 pixel
  logic [CFG_W:0] cr2, rad_r, rmin;
  assign cr2   = {corner_radius, 1'b0};
  assign rmin  = (cr2 < {1'b0, hole_width}) ? cr2 : {1'b0, hole_width};
  assign rad_r = (rmin < {1'b0, hole_height}) ? rmin : {1'b0, hole_height};

  // stage 1: offsets from the center, folded into the quadrant
  logic signed [GQ_W-1:0] dx, dy, adx, ady, qx, qy;
  logic [CFG_W:0]         wr, hr;
  logic                   v1;

  assign dx  = $signed({3'b0, pos_x, 1'b0})
             - ($signed({{3{hole_left[15]}}, hole_left, 1'b0}) + $signed({4'b0, hole_width}));
  assign dy  = $signed({3'b0, pos_y, 1'b0})
             - ($signed({{3{hole_top[15]}}, hole_top, 1'b0}) + $signed({4'b0, hole_height}));
  assign adx = dx[GQ_W-1] ? -dx : dx;
  assign ady = dy[GQ_W-1] ? -dy : dy;
  assign wr  = {1'b0, hole_width} - rad_r;
  assign hr  = {1'b0, hole_height} - rad_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    qx <= adx - $signed({3'b0, wr});
    qy <= ady - $signed({3'b0, hr});
  end

  // stage 2: squares and the straight-edge term
  logic [OX_W-1:0]        ox, oy;
  logic [SQR_W-1:0]       ox2, oy2;
  logic signed [GQ_W-1:0] mx, mn;
  logic signed [GQ_W:0]   mr;
  logic signed [DF_W-1:0] lin2, lin3;
  logic                   v2;

  assign ox = qx[GQ_W-1] ? '0 : qx[OX_W-1:0];
  assign oy = qy[GQ_W-1] ? '0 : qy[OX_W-1:0];
  assign mx = (qx > qy) ? qx : qy;
  assign mn = mx[GQ_W-1] ? mx : '0;
  assign mr = (GQ_W+1)'(mn) - $signed({{(GQ_W-CFG_W){1'b0}}, rad_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ox2  <= ox * ox;
    oy2  <= oy * oy;
    lin2 <= {mr, 8'd0};
  end

  // stage 3: radicand
  logic [RAD_W-1:0] rad;
  logic             v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    rad  <= RAD_W'({({1'b0, ox2} + {1'b0, oy2}), 16'd0});
    lin3 <= lin2;
  end

  // square root
  sq_side_t           sq_in, sq_out;
  logic [ROOT_W-1:0]  root;

  assign sq_in.valid = v3;
  assign sq_in.lin   = lin3;

  fsc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_side  (sq_in),
    .rad      (rad),
    .out_side (sq_out),
    .root     (root)
  );

  // signed distance, sign and magnitude
  logic signed [DF_W-1:0] df;
  pl_side_t               df_side;
  logic [ABS_W-1:0]       abs_df;

  assign df = $signed({{(DF_W-ROOT_W){1'b0}}, root}) + sq_out.lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      df_side.valid <= 1'b0;
    end else begin
      df_side.valid <= sq_out.valid;
    end
    df_side.neg <= df[DF_W-1];
    abs_df      <= df[DF_W-1] ? ABS_W'(-df) : ABS_W'(df);
  end

  // z = |d| / (sigma * sqrt2)
  pl_side_t       z_side;
  logic [Z_W-1:0] z;

  fsc_zdiv u_zdiv (
    .clk        (clk),
    .rst        (rst),
    .edge_sigma (edge_sigma),
    .in_side    (df_side),
    .abs_df     (abs_df),
    .out_side   (z_side),
    .z          (z)
  );

  // t = 1 / (1 + p*z)
  pl_side_t       t_side;
  logic [Z_W-1:0] t_z;
  logic [T_W-1:0] t;

  fsc_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .in_side  (z_side),
    .z        (z),
    .out_side (t_side),
    .out_z    (t_z),
    .t        (t)
  );

  // erf and coverage
  logic hard;
  assign hard = edge_sigma < HARD_SIGMA_LIMIT;

  fsc_erf u_erf (
    .clk      (clk),
    .rst      (rst),
    .hard     (hard),
    .in_side  (t_side),
    .z        (t_z),
    .t        (t),
    .done     (done),
    .coverage (coverage)
  );

`ifndef ASSERT_OFF
  // every request gives a result after the fixed latency
  a_latency_hit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("request without result at fixed latency");

  // no result without a request
  a_latency_miss: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##TOTAL_LAT !done)
    else $error("result without request");

  // hard edge gives only full or empty coverage
  a_hard_edge: assert property (@(posedge clk) disable iff (rst)
    (done && hard) |-> (coverage == 16'hFFFF || coverage == 16'h0000))
    else $error("hard edge coverage not binary");
`endif

endmodule

@@ verif/tb_feathered_rounded_rect_coverage.sv @@
// ----------------------------------------------------------------------------
// tb_feathered_rounded_rect_coverage
// Drives sample points through the coverage pipeline under several rectangle
// and sigma settings, predicts each coverage value with an integer model of
// the distance / erf arithmetic, and checks results in order.
// ----------------------------------------------------------------------------
module tb_feathered_rounded_rect_coverage;
  import fsc_pkg::*;

  localparam int PIPE_LAT  = 79;
  localparam int WDOG_MAX  = 4000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
  } point_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [15:0]       pos_x = '0;
  logic [15:0]       pos_y = '0;
  logic              wr_en = 1'b0;
  logic [IDX_W-1:0]  wr_index = '0;
  logic [CFG_W-1:0]  wr_data = '0;
  logic              done;
  logic [15:0]       coverage;

  // predictor copy of the registers
  logic [15:0] m_left, m_top, m_width, m_height, m_radius, m_sigma;

  point_t      point_q[$];
  logic [15:0] cov_q[$];
  int          fail_cnt = 0;
  int          wdog = 0;
  int          gap_left = 0;

  feathered_rounded_rect_coverage dut (.*);

  always #2 clk = ~clk;

  // 2^(-k/16) in Q16
  function automatic longint pow2_frac(input int k);
    longint tbl[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                        32768};
    return tbl[k];
  endfunction

  function automatic longint q16_round_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p < 0) return -((-p + 32768) >>> 16);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint exp_neg_q16(input longint u);
    longint v, n, f, i, w, e;
    v = (u * 94548) >>> 16;
    n = v >>> 16;
    f = v & 16'hFFFF;
    i = f >>> 12;
    w = f & 12'hFFF;
    if (n >= 17) return 0;
    e = pow2_frac(i) - (((pow2_frac(i) - pow2_frac(i + 1)) * w) >>> 12);
    return e >>> n;
  endfunction

  function automatic longint erf_q16(input longint z);
    longint den, t, p, u, y;
    den = 65536 + ((z * 21469) >>> 16);
    t   = ((64'd1 << 32) + den / 2) / den;
    u   = (z * z) >>> 16;
    p   = 69560;
    p   = q16_round_mul(p, t) - 95234;
    p   = q16_round_mul(p, t) + 93154;
    p   = q16_round_mul(p, t) - 18645;
    p   = q16_round_mul(p, t) + 16701;
    p   = q16_round_mul(p, t);
    y   = 65536 - q16_round_mul(p, exp_neg_q16(u));
    if (y < 0) y = 0;
    if (y > 65536) y = 65536;
    return y;
  endfunction

  function automatic logic [15:0] predict_coverage(input logic [15:0] px, input logic [15:0] py);
    longint w, h, r, cx2, cy2, qx, qy, ox, oy, mn, df, adf, z, e, c;
    w   = m_width;
    h   = m_height;
    r   = 2 * longint'(m_radius);
    if (w < r) r = w;
    if (h < r) r = h;
    cx2 = 2 * longint'($signed(m_left)) + w;
    cy2 = 2 * longint'($signed(m_top)) + h;
    qx  = 2 * longint'(px) - cx2;
    qy  = 2 * longint'(py) - cy2;
    if (qx < 0) qx = -qx;
    if (qy < 0) qy = -qy;
    qx  = qx - (w - r);
    qy  = qy - (h - r);
    ox  = qx > 0 ? qx : 0;
    oy  = qy > 0 ? qy : 0;
    mn  = qx > qy ? qx : qy;
    if (mn > 0) mn = 0;
    df  = int_sqrt((ox * ox + oy * oy) << 16) + 256 * (mn - r);
    if (m_sigma < HARD_SIGMA_LIMIT) return df < 0 ? 16'hFFFF : 16'h0000;
    adf = df < 0 ? -df : df;
    z   = (adf * 92682) / (64 * longint'(m_sigma));
    if (z > 524288) z = 524288;
    e   = erf_q16(z);
    c   = df < 0 ? (65536 + e) / 2 : (65536 - e) / 2;
    if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    fail_cnt++;
  endtask

  // write one register at a falling edge, block must be idle
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
    case (idx)
      REG_HOLE_LEFT:     m_left   = val;
      REG_HOLE_TOP:      m_top    = val;
      REG_HOLE_WIDTH:    m_width  = val;
      REG_HOLE_HEIGHT:   m_height = val;
      REG_CORNER_RADIUS: m_radius = val;
      REG_EDGE_SIGMA:    m_sigma  = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [15:0] l, input logic [15:0] t, input logic [15:0] w,
                           input logic [15:0] h, input logic [15:0] r, input logic [15:0] s);
    write_reg(REG_HOLE_LEFT, l);
    write_reg(REG_HOLE_TOP, t);
    write_reg(REG_HOLE_WIDTH, w);
    write_reg(REG_HOLE_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, r);
    write_reg(REG_EDGE_SIGMA, s);
  endtask

  task automatic push_point(input logic [15:0] x, input logic [15:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    point_q.push_back(p);
  endtask

  // let the queue drain and the pipeline empty before touching registers
  task automatic drain();
    while (point_q.size() != 0 || start || cov_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // random points, mostly near the rectangle edge
  task automatic random_points(input int n);
    int cx, cy, span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        push_point(16'($urandom), 16'($urandom));
      end else begin
        cx   = int'($signed(m_left)) + ($urandom_range(0, 1) ? int'(m_width) : 0);
        cy   = int'($signed(m_top)) + ($urandom_range(0, 1) ? int'(m_height) : 0);
        span = 16 + int'(m_sigma >> 2);
        push_point(16'(cx + $urandom_range(0, 2 * span) - span),
                   16'(cy + $urandom_range(0, 2 * span) - span));
      end
    end
  endtask

  // driver: one request per start, random gaps between requests
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the request until taken
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (point_q.size() != 0) begin
      start    <= 1'b1;
      pos_x    <= point_q[0].x;
      pos_y    <= point_q[0].y;
      void'(point_q.pop_front());
      gap_left <= ($urandom_range(0, 3) == 0) ? 0
                : int'($urandom_range(0, 18) * $urandom_range(0, 1));
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on accept, check on done
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (start && !busy) cov_q.push_back(predict_coverage(pos_x, pos_y));
      if (done) begin
        if (cov_q.size() == 0) begin
          report_mismatch($sformatf("unexpected coverage %0d", coverage));
        end else begin
          want = cov_q.pop_front();
          if (coverage !== want)
            report_mismatch($sformatf("coverage got %0d want %0d", coverage, want));
        end
      end
      if ((start && !busy) || done || (point_q.size() == 0 && cov_q.size() == 0 && !start)) begin
        wdog <= 0;
      end else begin
        wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    m_left = 0; m_top = 0; m_width = 0; m_height = 0; m_radius = 0; m_sigma = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: degenerate point rectangle at the origin, hard edge
    push_point(16'h0000, 16'h0000);
    push_point(16'hFFFF, 16'hFFFF);
    drain();

    // hard edge, oversized radius, extremes of position
    set_shape(16'd160, 16'd160, 16'd320, 16'd160, 16'hFFFF, 16'd2);
    push_point(16'd320, 16'd240);
    push_point(16'd160, 16'd160);
    push_point(16'd159, 16'd240);
    push_point(16'h0000, 16'hFFFF);
    push_point(16'hFFFF, 16'h0000);
    push_point(16'h5555, 16'hAAAA);
    random_points(40);
    drain();

    // moderate feather, small radius
    set_shape(16'd256, 16'd128, 16'd800, 16'd480, 16'd48, 16'd512);
    push_point(16'd656, 16'd368);
    push_point(16'd256, 16'd368);
    push_point(16'd255, 16'd128);
    push_point(16'hFFFF, 16'hFFFF);
    random_points(90);
    drain();

    // sigma at the hard limit, so the edge is still soft; rectangle beyond the grid
    set_shape(16'h8000, 16'h7FF0, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd3);
    push_point(16'h0000, 16'h0000);
    push_point(16'h7FFF, 16'hFFFF);
    random_points(60);
    drain();

    // widest sigma, empty width, unknown index ignored
    set_shape(16'hFFF0, 16'd32, 16'd0, 16'd64, 16'd8, 16'hFFFF);
    @(negedge clk);
    wr_en <= 1'b1; wr_index <= 3'd7; wr_data <= 16'h1234;
    @(negedge clk);
    wr_en <= 1'b0; wr_index <= 3'd6;
    push_point(16'hFFF0, 16'd64);
    push_point(16'h0000, 16'h0000);
    random_points(60);
    drain();

    // random shapes, back-to-back and gapped
    for (int k = 0; k < 3; k++) begin
      set_shape(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)), 16'($urandom),
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 4096)));
      random_points(50);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fsc_pkg.sv
rtl/core/fsc_sqrt.sv
rtl/core/fsc_zdiv.sv
rtl/core/fsc_recip.sv
rtl/core/fsc_erf.sv
rtl/core/feathered_rounded_rect_coverage.sv
verif/tb_feathered_rounded_rect_coverage.sv
